FILE: hdl/brb_pkg.sv
// Package for the byte ring buffer: operation and status codes, field widths,
// and the structs passed between the top level, controller and datapath.
// No dependencies.
`default_nettype none

package brb_pkg;

    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 11;

    // Operation codes carried in the kind field. The fourth code is a no-op.
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESET = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_DONE          = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_REFUSED_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_REFUSED_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED       = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] write_byte;
        logic              force_req;
        logic              block_start;
        logic              block_end;
    } brb_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   read_byte;
        logic [STATUS_W-1:0] status;
        logic [LEN_W-1:0]    fill_level;
        logic                is_full;
        logic                is_empty;
    } brb_result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the operation and fetch the byte at the read pointer
        logic exec;   // apply the operation and register its result
    } brb_cmd_t;

endpackage

`default_nettype wire

FILE: hdl/brb_if.sv
// Handshake channels of the byte ring buffer: the operation channel and the
// result channel. Depends on brb_pkg for the field widths.
`default_nettype none

interface brb_op_if
    import brb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] write_byte;
    logic              force_req;
    logic              block_start;
    logic              block_end;

    modport source (output valid, kind, write_byte, force_req, block_start, block_end,
                    input ready);
    modport sink   (input valid, kind, write_byte, force_req, block_start, block_end,
                    output ready);
endinterface

interface brb_rsp_if
    import brb_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   read_byte;
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    fill_level;
    logic                is_full;
    logic                is_empty;

    modport source (output valid, read_byte, status, fill_level, is_full, is_empty,
                    input ready);
    modport sink   (input valid, read_byte, status, fill_level, is_full, is_empty,
                    output ready);
endinterface

`default_nettype wire

FILE: hdl/brb_controller.sv
// Sequencing state machine of the byte ring buffer: accepts one operation,
// runs it in the execute state and owns the result valid flag. Depends on brb_pkg.
`default_nettype none

module brb_controller
    import brb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic op_valid,
    output logic      op_ready,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output brb_cmd_t  cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    // A new operation may enter in the idle state once the result slot is free or is
    // emptied in this same cycle; only one operation is ever in flight.
    assign op_ready  = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign rsp_valid = rsp_valid_reg;
    assign cmd.load  = op_valid && op_ready;
    assign cmd.exec  = (state_reg == ST_EXEC);

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next     = ST_IDLE;
                rsp_valid_next = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/brb_datapath.sv
// Datapath of the byte ring buffer: byte store, pointers, block flags, length
// register and the result register. Driven by brb_controller; depends on brb_pkg.
`default_nettype none

module brb_datapath
    import brb_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire brb_cmd_t         cmd,
    input  wire logic             cfg_we,
    input  wire logic [LEN_W-1:0] cfg_length,
    input  wire brb_item_t        item,
    output brb_result_t           result
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    logic [BYTE_W-1:0] byte_store [DEPTH];

    brb_item_t         item_reg;
    logic [BYTE_W-1:0] fetch_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic              last_write_reg;
    logic              last_write_next;
    logic              refused_reg;
    logic              refused_next;
    logic [CNT_W-1:0]  length_reg;
    brb_result_t       result_reg;
    brb_result_t       result_next;

    logic              store_we;
    logic              is_full;
    logic              is_empty;
    logic              refused_now;
    logic              full_after;
    logic [CMP_W-1:0]  rd_wide;
    logic [CMP_W-1:0]  wr_wide;
    logic [CMP_W-1:0]  len_wide;
    logic [CMP_W-1:0]  fill_wide;
    logic [CMP_W-1:0]  cfg_wide;
    logic [CMP_W-1:0]  cfg_clamped;

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr,
                                                 input logic [CNT_W-1:0] len);
        logic [CNT_W-1:0] inc;
        inc = CNT_W'(ptr) + CNT_W'(1);
        return (inc >= len) ? '0 : inc[PTR_W-1:0];
    endfunction

    assign result = result_reg;

    assign is_full  = (rd_ptr_reg == wr_ptr_reg) && last_write_reg;
    assign is_empty = (rd_ptr_reg == wr_ptr_reg) && !last_write_reg;

    // Lengths outside one to the store depth are clamped into that range.
    assign cfg_wide    = CMP_W'(cfg_length);
    assign cfg_clamped = (cfg_wide == '0) ? CMP_W'(1) :
                         (cfg_wide > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cfg_wide;

    always_comb
    begin
        rd_ptr_next           = rd_ptr_reg;
        wr_ptr_next           = wr_ptr_reg;
        last_write_next       = last_write_reg;
        refused_next          = refused_reg;
        store_we              = 1'b0;
        refused_now           = refused_reg;
        result_next.read_byte = '0;
        result_next.status    = STATUS_DONE;

        if (item_reg.kind == KIND_RESET)
        begin
            rd_ptr_next     = '0;
            wr_ptr_next     = '0;
            last_write_next = 1'b0;
            refused_next    = 1'b0;
        end
        else
        begin
            // The first item of a block decides whether the whole block is refused.
            if (item_reg.block_start)
            begin
                case (item_reg.kind)
                    KIND_WRITE: refused_now = is_full && !item_reg.force_req;
                    KIND_READ:  refused_now = is_empty;
                    default:    refused_now = 1'b0;
                endcase
            end
            if (refused_now)
            begin
                case (item_reg.kind)
                    KIND_WRITE: result_next.status = STATUS_REFUSED_FULL;
                    KIND_READ:  result_next.status = STATUS_REFUSED_EMPTY;
                    default:    result_next.status = STATUS_DONE;
                endcase
            end
            else if (item_reg.kind == KIND_WRITE)
            begin
                if (is_full)
                begin
                    result_next.status = STATUS_DROPPED;
                end
                else
                begin
                    store_we        = 1'b1;
                    wr_ptr_next     = advance(wr_ptr_reg, length_reg);
                    last_write_next = 1'b1;
                end
                // A forced block ends with the buffer counted as full.
                if (item_reg.block_end && item_reg.force_req)
                begin
                    rd_ptr_next     = wr_ptr_next;
                    last_write_next = 1'b1;
                end
            end
            else if (item_reg.kind == KIND_READ)
            begin
                if (is_empty)
                begin
                    result_next.status = STATUS_DROPPED;
                end
                else
                begin
                    result_next.read_byte = fetch_reg;
                    rd_ptr_next           = advance(rd_ptr_reg, length_reg);
                    last_write_next       = 1'b0;
                end
            end
            refused_next = item_reg.block_end ? 1'b0 : refused_now;
        end

        full_after = (rd_ptr_next == wr_ptr_next) && last_write_next;
        rd_wide    = CMP_W'(rd_ptr_next);
        wr_wide    = CMP_W'(wr_ptr_next);
        len_wide   = CMP_W'(length_reg);
        if (full_after)
        begin
            fill_wide = len_wide;
        end
        else if (wr_wide >= rd_wide)
        begin
            fill_wide = wr_wide - rd_wide;
        end
        else
        begin
            fill_wide = wr_wide + len_wide - rd_wide;
        end
        result_next.fill_level = fill_wide[LEN_W-1:0];
        result_next.is_full    = full_after;
        result_next.is_empty   = (rd_ptr_next == wr_ptr_next) && !last_write_next;
    end

    // Byte store: the byte at the read pointer is fetched as the operation is
    // taken, and a write lands at the end of the execute cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            fetch_reg <= byte_store[rd_ptr_reg];
        end
        if (cmd.exec && store_we)
        begin
            byte_store[wr_ptr_reg] <= item_reg.write_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        if (cmd.exec)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            last_write_reg <= 1'b0;
            refused_reg    <= 1'b0;
            length_reg     <= CNT_W'(DEPTH);
        end
        else if (cfg_we)
        begin
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            last_write_reg <= 1'b0;
            refused_reg    <= 1'b0;
            length_reg     <= cfg_clamped[CNT_W-1:0];
        end
        else if (cmd.exec)
        begin
            rd_ptr_reg     <= rd_ptr_next;
            wr_ptr_reg     <= wr_ptr_next;
            last_write_reg <= last_write_next;
            refused_reg    <= refused_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/byte_ring_buffer.sv
// Top level of the byte ring buffer: joins the controller and the datapath to
// the operation, result and length channels. Depends on brb_pkg, brb_if,
// brb_controller and brb_datapath.
//
//   Channel      Direction  Handshake          Payload
//   op           in         valid / ready      kind, write_byte, force_req,
//                                              block_start, block_end
//   rsp          out        valid / ready      read_byte, status, fill_level,
//                                              is_full, is_empty
//   cfg_length   in         cfg_we, no stall   usable length, 11 bits
//
// In each transaction the byte at the read pointer is fetched as the operation is
// accepted; the pointers and the result register are updated in the execute state.
// The registered read port of the byte store is why the fetch comes first.
// Reset clears the pointers and block flags and sets the length to DEPTH; the byte
// store is not cleared and needs no clearing pass.
// A result waiting for rsp.ready holds; a new operation is taken in the cycle that
// result leaves, so a slow sink costs no extra bubble.
`default_nettype none

module byte_ring_buffer
    import brb_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    brb_op_if.sink                op,
    brb_rsp_if.source             rsp,
    input  wire logic             cfg_we,
    input  wire logic [LEN_W-1:0] cfg_length
);

    brb_cmd_t    cmd;
    brb_item_t   item;
    brb_result_t result;

    // The controller only sequences; all state of the ring lives in the datapath.
    brb_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op.valid),
        .op_ready  (op.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    assign item.kind        = op.kind;
    assign item.write_byte  = op.write_byte;
    assign item.force_req   = op.force_req;
    assign item.block_start = op.block_start;
    assign item.block_end   = op.block_end;

    brb_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg_we     (cfg_we),
        .cfg_length (cfg_length),
        .item       (item),
        .result     (result)
    );

    // The result payload comes straight from the datapath's result register.
    assign rsp.read_byte  = result.read_byte;
    assign rsp.status     = result.status;
    assign rsp.fill_level = result.fill_level;
    assign rsp.is_full    = result.is_full;
    assign rsp.is_empty   = result.is_empty;

endmodule

`default_nettype wire
